FILE: src/scpf_pkg.sv
// Shared widths, types and register codes for the sphere contact force unit.
package scpf_pkg;

   localparam int PosW   = 20;
   localparam int DiffW  = 21;
   localparam int SqW    = 42;
   localparam int DsqW   = 34;
   localparam int RootW  = 17;
   localparam int CfgW   = 16;
   localparam int MagW   = 33;
   localparam int NumW   = 42;
   localparam int QuoW   = 25;
   localparam int ForceW = 32;
   localparam int CsrIdxW = 2;

   localparam logic [CsrIdxW-1:0] CsrToolRadius       = 2'd0;
   localparam logic [CsrIdxW-1:0] CsrNodeRadius       = 2'd1;
   localparam logic [CsrIdxW-1:0] CsrContactStiffness = 2'd2;

   localparam logic [CfgW-1:0] ToolRadiusReset = 16'd6554;
   localparam logic [CfgW-1:0] NodeRadiusReset = 16'd4588;
   localparam logic [CfgW-1:0] StiffnessReset  = 16'd10240;

   // Travels with an item through the square root pipe.
   typedef struct packed {
      logic             contact;
      logic [2:0]       neg;
      logic [RootW-1:0] ax;
      logic [RootW-1:0] ay;
      logic [RootW-1:0] az;
   } geo_type;

   // Travels with an item through the divider pipe.
   typedef struct packed {
      logic       contact;
      logic [2:0] neg;
   } tag_type;

endpackage

FILE: src/scpf_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module scpf_sqrt (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic [scpf_pkg::DsqW-1:0]  in_rad,
   input  scpf_pkg::geo_type      in_side,
   output logic                   out_valid,
   output logic [scpf_pkg::RootW-1:0] out_root,
   output scpf_pkg::geo_type      out_side
);
   import scpf_pkg::*;

   localparam int RemW = RootW + 1;

   logic                v_ff    [0:RootW];
   logic [RemW-1:0]     rem_ff  [0:RootW];
   logic [RootW-1:0]    root_ff [0:RootW];
   logic [DsqW-1:0]     rad_ff  [0:RootW];
   geo_type             side_ff [0:RootW];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else begin
         v_ff[0] <= in_valid;
      end
      rem_ff[0]  <= '0;
      root_ff[0] <= '0;
      rad_ff[0]  <= in_rad;
      side_ff[0] <= in_side;
   end

   for (genvar k = 0; k < RootW; k++) begin : g_step
      logic [RemW+1:0]  acc;
      logic [RemW+1:0]  trial;
      logic             ge;
      logic [RemW-1:0]  rem_in;
      logic [RootW-1:0] root_in;

      // bring down the next two radicand bits, try root*4+1
      assign acc     = {rem_ff[k], rad_ff[k][DsqW-1-2*k -: 2]};
      assign trial   = {1'b0, root_ff[k], 2'b01};
      assign ge      = (acc >= trial);
      assign rem_in  = ge ? RemW'(acc - trial) : acc[RemW-1:0];
      assign root_in = {root_ff[k][RootW-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else begin
            v_ff[k+1] <= v_ff[k];
         end
         rem_ff[k+1]  <= rem_in;
         root_ff[k+1] <= root_in;
         rad_ff[k+1]  <= rad_ff[k];
         side_ff[k+1] <= side_ff[k];
      end
   end

   assign out_valid = v_ff[RootW];
   assign out_root  = root_ff[RootW];
   assign out_side  = side_ff[RootW];

endmodule

FILE: src/scpf_div.sv
// Three-lane pipelined restoring divider sharing one divisor, one quotient bit per stage.
module scpf_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic [scpf_pkg::NumW-1:0]   in_num_x,
   input  logic [scpf_pkg::NumW-1:0]   in_num_y,
   input  logic [scpf_pkg::NumW-1:0]   in_num_z,
   input  logic [scpf_pkg::RootW-1:0]  in_den,
   input  scpf_pkg::tag_type           in_tag,
   output logic                        out_valid,
   output logic [scpf_pkg::QuoW-1:0]   out_quo_x,
   output logic [scpf_pkg::QuoW-1:0]   out_quo_y,
   output logic [scpf_pkg::QuoW-1:0]   out_quo_z,
   output scpf_pkg::tag_type           out_tag
);
   import scpf_pkg::*;

   logic             v_ff   [0:QuoW];
   logic [RootW-1:0] den_ff [0:QuoW];
   tag_type          tag_ff [0:QuoW];
   logic [RootW-1:0] rem_ff [0:QuoW][0:2];
   logic [QuoW-1:0]  quo_ff [0:QuoW][0:2];

   // quotient fits in QuoW bits on the contact path, so the top bits start as remainder
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else begin
         v_ff[0] <= in_valid;
      end
      den_ff[0]    <= in_den;
      tag_ff[0]    <= in_tag;
      rem_ff[0][0] <= in_num_x[NumW-1:QuoW];
      rem_ff[0][1] <= in_num_y[NumW-1:QuoW];
      rem_ff[0][2] <= in_num_z[NumW-1:QuoW];
      quo_ff[0][0] <= in_num_x[QuoW-1:0];
      quo_ff[0][1] <= in_num_y[QuoW-1:0];
      quo_ff[0][2] <= in_num_z[QuoW-1:0];
   end

   for (genvar k = 0; k < QuoW; k++) begin : g_step
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else begin
            v_ff[k+1] <= v_ff[k];
         end
         den_ff[k+1] <= den_ff[k];
         tag_ff[k+1] <= tag_ff[k];
      end

      for (genvar l = 0; l < 3; l++) begin : g_lane
         logic [RootW:0]   acc;
         logic             ge;
         logic [RootW-1:0] rem_in;
         logic [QuoW-1:0]  quo_in;

         assign acc    = {rem_ff[k][l], quo_ff[k][l][QuoW-1]};
         assign ge     = (acc >= {1'b0, den_ff[k]});
         assign rem_in = ge ? RootW'(acc - {1'b0, den_ff[k]}) : acc[RootW-1:0];
         assign quo_in = {quo_ff[k][l][QuoW-2:0], ge};

         always_ff @(posedge clock) begin
            rem_ff[k+1][l] <= rem_in;
            quo_ff[k+1][l] <= quo_in;
         end
      end
   end

   assign out_valid = v_ff[QuoW];
   assign out_quo_x = quo_ff[QuoW][0];
   assign out_quo_y = quo_ff[QuoW][1];
   assign out_quo_z = quo_ff[QuoW][2];
   assign out_tag   = tag_ff[QuoW];

endmodule

FILE: src/sphere_contact_penalty_force_unit.sv
// Top level: sphere-sphere penalty contact force pipeline.
//
//  channel   ports                            handshake
//  request   start, req_tool_*, req_node_*    taken when start & !busy
//  response  rsp_valid, rsp_force_*, rsp_in_contact  one-cycle strobe
//  csr       csr_write_en, csr_index, csr_data       write, no wait
//
// One item enters per cycle; busy stays low. Each item's result strobes after the
// 17-stage square root, the 25-stage divider and the other registered stages.
// Synchronous reset clears the valid bits and loads the register defaults.
// The receiver cannot stall, so the pipe advances every cycle.
module sphere_contact_penalty_force_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic signed [scpf_pkg::PosW-1:0] req_tool_x,
   input  logic signed [scpf_pkg::PosW-1:0] req_tool_y,
   input  logic signed [scpf_pkg::PosW-1:0] req_tool_z,
   input  logic signed [scpf_pkg::PosW-1:0] req_node_x,
   input  logic signed [scpf_pkg::PosW-1:0] req_node_y,
   input  logic signed [scpf_pkg::PosW-1:0] req_node_z,
   output logic                           rsp_valid,
   output logic signed [scpf_pkg::ForceW-1:0] rsp_force_x,
   output logic signed [scpf_pkg::ForceW-1:0] rsp_force_y,
   output logic signed [scpf_pkg::ForceW-1:0] rsp_force_z,
   output logic                           rsp_in_contact,
   input  logic                           csr_write_en,
   input  logic [scpf_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [scpf_pkg::CfgW-1:0]      csr_data
);
   import scpf_pkg::*;

   // configuration
   logic [CfgW-1:0]   tool_radius_ff, node_radius_ff, stiffness_ff;
   logic [RootW-1:0]  r_ff;
   logic [DsqW-1:0]   rr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tool_radius_ff <= ToolRadiusReset;
         node_radius_ff <= NodeRadiusReset;
         stiffness_ff   <= StiffnessReset;
      end else if (csr_write_en) begin
         case (csr_index)
            CsrToolRadius:       tool_radius_ff <= csr_data;
            CsrNodeRadius:       node_radius_ff <= csr_data;
            CsrContactStiffness: stiffness_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // derived sums settle while idle after a write
   always_ff @(posedge clock) begin
      r_ff  <= {1'b0, tool_radius_ff} + {1'b0, node_radius_ff};
      rr_ff <= DsqW'(r_ff) * DsqW'(r_ff);
   end

   assign busy = 1'b0;

   // stage A: offsets
   logic                    a_v_ff;
   logic signed [DiffW-1:0] dx_ff, dy_ff, dz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else begin
         a_v_ff <= start;
      end
      dx_ff <= DiffW'(req_tool_x) - DiffW'(req_node_x);
      dy_ff <= DiffW'(req_tool_y) - DiffW'(req_node_y);
      dz_ff <= DiffW'(req_tool_z) - DiffW'(req_node_z);
   end

   // stage B: squares, magnitudes
   logic signed [SqW-1:0] px, py, pz;
   logic [DiffW-1:0]      ax, ay, az;
   logic                  b_v_ff;
   logic [SqW-1:0]        sqx_ff, sqy_ff, sqz_ff;
   logic [2:0]            b_neg_ff;
   logic [RootW-1:0]      b_ax_ff, b_ay_ff, b_az_ff;

   assign px = SqW'(dx_ff) * SqW'(dx_ff);
   assign py = SqW'(dy_ff) * SqW'(dy_ff);
   assign pz = SqW'(dz_ff) * SqW'(dz_ff);
   assign ax = dx_ff[DiffW-1] ? DiffW'(-dx_ff) : DiffW'(dx_ff);
   assign ay = dy_ff[DiffW-1] ? DiffW'(-dy_ff) : DiffW'(dy_ff);
   assign az = dz_ff[DiffW-1] ? DiffW'(-dz_ff) : DiffW'(dz_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff <= 1'b0;
      end else begin
         b_v_ff <= a_v_ff;
      end
      sqx_ff   <= $unsigned(px);
      sqy_ff   <= $unsigned(py);
      sqz_ff   <= $unsigned(pz);
      b_neg_ff <= {dz_ff[DiffW-1], dy_ff[DiffW-1], dx_ff[DiffW-1]};
      // on the contact path each |d| is at most the length, so 17 bits suffice
      b_ax_ff  <= ax[RootW-1:0];
      b_ay_ff  <= ay[RootW-1:0];
      b_az_ff  <= az[RootW-1:0];
   end

   // stage C: squared length and contact test
   logic [SqW+1:0]  dsq;
   logic            c_v_ff;
   logic [DsqW-1:0] c_dsq_ff;
   geo_type         c_side_ff;

   assign dsq = {2'b00, sqx_ff} + {2'b00, sqy_ff} + {2'b00, sqz_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         c_v_ff <= 1'b0;
      end else begin
         c_v_ff <= b_v_ff;
      end
      c_dsq_ff          <= dsq[DsqW-1:0];
      c_side_ff.contact <= (dsq != '0) && (dsq <= {{(SqW+2-DsqW){1'b0}}, rr_ff});
      c_side_ff.neg     <= b_neg_ff;
      c_side_ff.ax      <= b_ax_ff;
      c_side_ff.ay      <= b_ay_ff;
      c_side_ff.az      <= b_az_ff;
   end

   // length
   logic             s_v;
   logic [RootW-1:0] s_root;
   geo_type          s_side;

   scpf_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c_v_ff),
      .in_rad    (c_dsq_ff),
      .in_side   (c_side_ff),
      .out_valid (s_v),
      .out_root  (s_root),
      .out_side  (s_side)
   );

   // stage E: penetration
   logic             e_v_ff;
   logic [RootW-1:0] e_pen_ff, e_len_ff;
   geo_type          e_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_v_ff <= 1'b0;
      end else begin
         e_v_ff <= s_v;
      end
      e_pen_ff  <= r_ff - s_root;
      e_len_ff  <= s_root;
      e_side_ff <= s_side;
   end

   // stage F: magnitude = penetration * stiffness
   logic             f_v_ff;
   logic [MagW-1:0]  f_mag_ff;
   logic [RootW-1:0] f_len_ff;
   geo_type          f_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f_v_ff <= 1'b0;
      end else begin
         f_v_ff <= e_v_ff;
      end
      f_mag_ff  <= MagW'(e_pen_ff) * MagW'(stiffness_ff);
      f_len_ff  <= e_len_ff;
      f_side_ff <= e_side_ff;
   end

   // stage G: numerators, scaled down by 256 ahead of the divide
   logic [MagW+RootW-1:0] nx, ny, nz;
   logic                  g_v_ff;
   logic [NumW-1:0]       g_nx_ff, g_ny_ff, g_nz_ff;
   logic [RootW-1:0]      g_len_ff;
   tag_type               g_tag_ff;

   assign nx = (MagW+RootW)'(f_mag_ff) * (MagW+RootW)'(f_side_ff.ax);
   assign ny = (MagW+RootW)'(f_mag_ff) * (MagW+RootW)'(f_side_ff.ay);
   assign nz = (MagW+RootW)'(f_mag_ff) * (MagW+RootW)'(f_side_ff.az);

   always_ff @(posedge clock) begin
      if (reset) begin
         g_v_ff <= 1'b0;
      end else begin
         g_v_ff <= f_v_ff;
      end
      g_nx_ff          <= nx[MagW+RootW-1:8];
      g_ny_ff          <= ny[MagW+RootW-1:8];
      g_nz_ff          <= nz[MagW+RootW-1:8];
      g_len_ff         <= f_len_ff;
      g_tag_ff.contact <= f_side_ff.contact;
      g_tag_ff.neg     <= f_side_ff.neg;
   end

   // divide by length
   logic            q_v;
   logic [QuoW-1:0] qx, qy, qz;
   tag_type         q_tag;

   scpf_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (g_v_ff),
      .in_num_x  (g_nx_ff),
      .in_num_y  (g_ny_ff),
      .in_num_z  (g_nz_ff),
      .in_den    (g_len_ff),
      .in_tag    (g_tag_ff),
      .out_valid (q_v),
      .out_quo_x (qx),
      .out_quo_y (qy),
      .out_quo_z (qz),
      .out_tag   (q_tag)
   );

   // output stage: sign and contact gating; the quotient never reaches saturation
   logic [ForceW-1:0] ux, uy, uz;
   logic              rsp_valid_ff, rsp_in_contact_ff;
   logic [ForceW-1:0] fx_ff, fy_ff, fz_ff;

   assign ux = ForceW'(qx);
   assign uy = ForceW'(qy);
   assign uz = ForceW'(qz);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= q_v;
      end
      rsp_in_contact_ff <= q_tag.contact;
      fx_ff <= !q_tag.contact ? '0 : (q_tag.neg[0] ? ForceW'(-ux) : ux);
      fy_ff <= !q_tag.contact ? '0 : (q_tag.neg[1] ? ForceW'(-uy) : uy);
      fz_ff <= !q_tag.contact ? '0 : (q_tag.neg[2] ? ForceW'(-uz) : uz);
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_in_contact = rsp_in_contact_ff;
   assign rsp_force_x    = $signed(fx_ff);
   assign rsp_force_y    = $signed(fy_ff);
   assign rsp_force_z    = $signed(fz_ff);

endmodule
